FILE: hdl/bilateral_filter_window_defines.svh
// Assertion macros shared by the bilateral filter window RTL.
`ifndef BILATERAL_FILTER_WINDOW_DEFINES_SVH
`define BILATERAL_FILTER_WINDOW_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BFW_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define BFW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bfw_pkg.sv
// Shared constants and types of the bilateral filter window.
`timescale 1ns / 1ps
package bfw_pkg;
	localparam int WINDOW_RADIUS = 2;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 1;
	localparam int PIX_W = 8;
	localparam int INDEX_W = 8;
	localparam int WEIGHT_W = 16;
	localparam int PRODW_W = 2 * WEIGHT_W;
	localparam int PROD_W = PRODW_W + PIX_W;

	localparam logic [1:0] FUNC_PIXEL = 2'd0;
	localparam logic [1:0] FUNC_SPATIAL = 2'd1;
	localparam logic [1:0] FUNC_RANGE = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef struct packed {
		logic adv;
		logic shift;
		logic rw_we;
		logic [INDEX_W-1:0] index;
		logic [WEIGHT_W-1:0] weight;
	} bfw_cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic [PIX_W-1:0] centre;
	} bfw_meta_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic [PIX_W-1:0] pixel;
	} bfw_result_t;
endpackage

FILE: hdl/bfw_cell.sv
// One window tap: pixel register, spatial weight, range table copy and weight products.
`timescale 1ns / 1ps
module bfw_cell (
	input logic clk,
	input logic arst_n,
	input bfw_pkg::bfw_cell_ctl_t ctl,
	input logic sw_we,
	input logic [bfw_pkg::PIX_W-1:0] tap_in,
	input logic [bfw_pkg::PIX_W-1:0] centre,
	output logic [bfw_pkg::PIX_W-1:0] tap,
	output logic [bfw_pkg::PROD_W-1:0] prod,
	output logic [bfw_pkg::PRODW_W-1:0] wgt
);
	logic [bfw_pkg::PIX_W-1:0] tap_q;
	logic [bfw_pkg::WEIGHT_W-1:0] sw_q;
	logic [bfw_pkg::WEIGHT_W-1:0] rw_mem [1 << bfw_pkg::INDEX_W];
	logic [bfw_pkg::PIX_W-1:0] diff;
	logic [bfw_pkg::WEIGHT_W-1:0] rw_s3;
	logic [bfw_pkg::WEIGHT_W-1:0] sw_s3;
	logic [bfw_pkg::PIX_W-1:0] q_s3;
	logic [bfw_pkg::PRODW_W-1:0] w_s4;
	logic [bfw_pkg::PIX_W-1:0] q_s4;
	logic [bfw_pkg::PROD_W-1:0] prod_s5;
	logic [bfw_pkg::PRODW_W-1:0] w_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.adv && ctl.shift) begin
			tap_q <= tap_in;
		end
	end

	assign diff = (tap_q >= centre) ? tap_q - centre : centre - tap_q;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rw_s3 <= rw_mem[diff];
			sw_s3 <= sw_q;
			q_s3 <= tap_q;
			if (ctl.rw_we) begin
				rw_mem[ctl.index] <= ctl.weight;
			end
			if (sw_we) begin
				sw_q <= ctl.weight;
			end
			w_s4 <= bfw_pkg::PRODW_W'(sw_s3) * bfw_pkg::PRODW_W'(rw_s3);
			q_s4 <= q_s3;
			prod_s5 <= bfw_pkg::PROD_W'(w_s4) * bfw_pkg::PROD_W'(q_s4);
			w_s5 <= w_s4;
		end
	end

	assign tap = tap_q;
	assign prod = prod_s5;
	assign wgt = w_s5;
endmodule

FILE: hdl/bfw_adder_tree.sv
// Registered binary adder tree over the tap products.
`timescale 1ns / 1ps
module bfw_adder_tree #(
	parameter int N = 25,
	parameter int W_IN = 40,
	parameter int W_OUT = 45
) (
	input logic clk,
	input logic adv,
	input logic [N-1:0][W_IN-1:0] leaves,
	output logic [W_OUT-1:0] sum
);
	localparam int LEVELS = $clog2(N);
	localparam int P = 1 << LEVELS;

	logic [W_OUT-1:0] leaf [P];
	logic [W_OUT-1:0] node_q [1:P-1];

	for (genvar j = 0; j < P; j++) begin : g_leaf
		if (j < N) begin : g_used
			assign leaf[j] = W_OUT'(leaves[j]);
		end else begin : g_zero
			assign leaf[j] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 1; i < P; i++) begin
				if (2 * i >= P) begin
					node_q[i] <= leaf[2 * i - P] + leaf[2 * i + 1 - P];
				end else begin
					node_q[i] <= node_q[2 * i] + node_q[2 * i + 1];
				end
			end
		end
	end

	assign sum = node_q[1];
endmodule

FILE: hdl/bfw_divider.sv
// Pipelined restoring divider giving the rounded weighted mean, one quotient bit per stage.
`timescale 1ns / 1ps
module bfw_divider #(
	parameter int NUM_W = 45,
	parameter int DEN_W = 37
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	input bfw_pkg::bfw_meta_t meta_in,
	output bfw_pkg::bfw_result_t result
);
	localparam int XW = NUM_W + 2;
	localparam int QW = bfw_pkg::PIX_W;

	logic [XW-1:0] rem_q [QW+1];
	logic [XW-1:0] d_q [QW+1];
	logic [QW-1:0] quo_q [QW+1];
	logic zero_q [QW+1];
	bfw_pkg::bfw_meta_t meta_q [QW+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= (XW'(num) << 1) + XW'(den);
			d_q[0] <= XW'(den) << 1;
			quo_q[0] <= '0;
			zero_q[0] <= (den == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q[0] <= '0;
		end else if (adv) begin
			meta_q[0] <= meta_in;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int SH = QW - 1 - j;
		logic [XW-1:0] dsh;
		assign dsh = d_q[j] << SH;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_q[j] >= dsh) begin
					rem_q[j+1] <= rem_q[j] - dsh;
					quo_q[j+1] <= quo_q[j] | (QW'(1) << SH);
				end else begin
					rem_q[j+1] <= rem_q[j];
					quo_q[j+1] <= quo_q[j];
				end
				d_q[j+1] <= d_q[j];
				zero_q[j+1] <= zero_q[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_q[j+1] <= '0;
			end else if (adv) begin
				meta_q[j+1] <= meta_q[j];
			end
		end
	end

	assign result.valid = meta_q[QW].valid;
	assign result.last = meta_q[QW].last;
	assign result.pixel = zero_q[QW] ? meta_q[QW].centre : quo_q[QW];
endmodule

FILE: hdl/bilateral_filter_window.sv
// Top level of the streaming bilateral filter over a square pixel window.
//
// Items arrive on the item channel (item_valid, item_stall). A pixel item carries
// one pixel of the zero-padded frame in raster order; a table item loads one
// spatial or range weight and gives no result. Results leave on the result
// channel (result_valid, result_stall), one per interior pixel, in order.
// The block takes one item per cycle while item_stall is low. A result is formed
// from the pixel transfer that completes its window by, in order: line buffer
// read, window shift, range table read, two multiplies, the adder tree, and a
// divider that resolves one quotient bit per stage, then the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// item_stall rises; nothing is dropped. The image size must be written on the
// register port only while the block is idle; the block does not enforce this.
// Each write restarts the frame. Reset clears the frame position, the window and
// all pipeline valid flags; line buffer and weight tables hold nothing defined
// until they are written, so weights must be loaded before the first frame.
`timescale 1ns / 1ps
`include "bilateral_filter_window_defines.svh"
module bilateral_filter_window #(
	parameter int WINDOW_RADIUS = bfw_pkg::WINDOW_RADIUS,
	parameter int MAX_WIDTH = bfw_pkg::MAX_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic [1:0] func,
	input logic [bfw_pkg::PIX_W-1:0] pixel,
	input logic [bfw_pkg::INDEX_W-1:0] table_index,
	input logic [bfw_pkg::WEIGHT_W-1:0] weight,
	output logic result_valid,
	input logic result_stall,
	output logic [bfw_pkg::PIX_W-1:0] pixel_out,
	output logic last_of_frame,
	input logic write_en,
	input logic [bfw_pkg::CFG_INDEX_W-1:0] write_index,
	input logic [bfw_pkg::CFG_DATA_W-1:0] write_data
);
	localparam int SIDE = 2 * WINDOW_RADIUS + 1;
	localparam int TAPS = SIDE * SIDE;
	localparam int LROWS = 2 * WINDOW_RADIUS;
	localparam int LINE_LEN = MAX_WIDTH + 2 * WINDOW_RADIUS;
	localparam int COL_W = $clog2(LINE_LEN);
	localparam int PW_W = $clog2(LINE_LEN + 1);
	localparam int ROW_W = $clog2(bfw_pkg::MAX_HEIGHT + 2 * WINDOW_RADIUS + 1);
	localparam int LEVELS = $clog2(TAPS);
	localparam int NUM_W = bfw_pkg::PROD_W + LEVELS;
	localparam int DEN_W = bfw_pkg::PRODW_W + LEVELS;
	localparam int PIX_W = bfw_pkg::PIX_W;

	logic adv;
	logic accept;
	logic [bfw_pkg::WIDTH_REG_W-1:0] width_q;
	logic [bfw_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [PW_W-1:0] eff_w;
	logic [PW_W-1:0] pw;
	logic [ROW_W-1:0] eff_h;
	logic [ROW_W-1:0] ph;
	logic [COL_W-1:0] col;
	logic pad;
	logic emit;
	logic is_last;
	logic pix_acc;
	logic [PIX_W-1:0] p;

	logic [LROWS*PIX_W-1:0] line_mem [LINE_LEN];
	logic [LROWS*PIX_W-1:0] line_rd_s1;

	logic pix_s1;
	logic res_s1;
	logic last_s1;
	logic rw_s1;
	logic sw_s1;
	logic [PIX_W-1:0] p_s1;
	logic [COL_W-1:0] col_s1;
	logic [bfw_pkg::INDEX_W-1:0] idx_s1;
	logic [bfw_pkg::WEIGHT_W-1:0] wt_s1;
	logic res_s2;
	logic last_s2;
	logic rw_s2;
	logic sw_s2;
	logic [bfw_pkg::INDEX_W-1:0] idx_s2;
	logic [bfw_pkg::WEIGHT_W-1:0] wt_s2;
	bfw_pkg::bfw_meta_t m_s3;
	bfw_pkg::bfw_meta_t m_s4;
	bfw_pkg::bfw_meta_t m_s5;
	bfw_pkg::bfw_meta_t tree_meta_q [LEVELS];

	bfw_pkg::bfw_cell_ctl_t cell_ctl;
	logic [PIX_W-1:0] colin [SIDE];
	logic [PIX_W-1:0] tap [TAPS];
	logic [TAPS-1:0][bfw_pkg::PROD_W-1:0] prods;
	logic [TAPS-1:0][bfw_pkg::PRODW_W-1:0] wgts;
	logic [NUM_W-1:0] num_sum;
	logic [DEN_W-1:0] den_sum;
	bfw_pkg::bfw_result_t div_res;

	logic result_valid_q;
	logic last_q;
	logic [PIX_W-1:0] pixel_out_q;

	assign adv = !result_valid_q || !result_stall;
	assign item_stall = !adv;
	assign accept = item_valid && adv;
	assign pix_acc = accept && (func == bfw_pkg::FUNC_PIXEL);

	assign eff_w = (32'(width_q) > MAX_WIDTH) ? PW_W'(MAX_WIDTH) : PW_W'(width_q);
	assign eff_h = (32'(height_q) > bfw_pkg::MAX_HEIGHT) ?
		ROW_W'(bfw_pkg::MAX_HEIGHT) : ROW_W'(height_q);
	assign pw = eff_w + PW_W'(2 * WINDOW_RADIUS);
	assign ph = eff_h + ROW_W'(2 * WINDOW_RADIUS);
	assign col = (PW_W'(column_count_q) >= pw) ? '0 : column_count_q;

	assign pad = (row_count_q < ROW_W'(WINDOW_RADIUS)) ||
		(row_count_q >= ROW_W'(WINDOW_RADIUS) + eff_h) ||
		(PW_W'(col) < PW_W'(WINDOW_RADIUS)) ||
		(PW_W'(col) >= PW_W'(WINDOW_RADIUS) + eff_w);
	assign p = pad ? '0 : pixel;
	assign emit = (row_count_q >= ROW_W'(2 * WINDOW_RADIUS)) && (row_count_q < ph) &&
		(PW_W'(col) >= PW_W'(2 * WINDOW_RADIUS));
	assign is_last = (row_count_q == ph - ROW_W'(1)) && (PW_W'(col) == pw - PW_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= bfw_pkg::WIDTH_REG_W'(640);
			height_q <= bfw_pkg::HEIGHT_REG_W'(480);
			column_count_q <= '0;
			row_count_q <= '0;
		end else if (write_en) begin
			unique case (write_index)
				bfw_pkg::REG_IMAGE_WIDTH: width_q <= write_data[bfw_pkg::WIDTH_REG_W-1:0];
				bfw_pkg::REG_IMAGE_HEIGHT: height_q <= write_data;
				default: ;
			endcase
			column_count_q <= '0;
			row_count_q <= '0;
		end else if (pix_acc) begin
			if (PW_W'(col) + PW_W'(1) >= pw) begin
				column_count_q <= '0;
				row_count_q <= (row_count_q + ROW_W'(1) >= ph) ? '0 : row_count_q + ROW_W'(1);
			end else begin
				column_count_q <= col + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_rd_s1 <= line_mem[col];
			if (pix_s1) begin
				line_mem[col_s1] <= {p_s1, line_rd_s1[LROWS*PIX_W-1:PIX_W]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			res_s1 <= 1'b0;
			rw_s1 <= 1'b0;
			sw_s1 <= 1'b0;
			res_s2 <= 1'b0;
			rw_s2 <= 1'b0;
			sw_s2 <= 1'b0;
			m_s3 <= '0;
			m_s4 <= '0;
			m_s5 <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				tree_meta_q[i] <= '0;
			end
			result_valid_q <= 1'b0;
		end else if (adv) begin
			pix_s1 <= pix_acc;
			res_s1 <= pix_acc && emit;
			rw_s1 <= accept && (func == bfw_pkg::FUNC_RANGE);
			sw_s1 <= accept && (func == bfw_pkg::FUNC_SPATIAL);
			res_s2 <= res_s1;
			rw_s2 <= rw_s1;
			sw_s2 <= sw_s1;
			m_s3 <= '{valid: res_s2, last: last_s2, centre: tap[WINDOW_RADIUS * SIDE + WINDOW_RADIUS]};
			m_s4 <= m_s3;
			m_s5 <= m_s4;
			tree_meta_q[0] <= m_s5;
			for (int i = 1; i < LEVELS; i++) begin
				tree_meta_q[i] <= tree_meta_q[i-1];
			end
			result_valid_q <= div_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= is_last;
			p_s1 <= p;
			col_s1 <= col;
			idx_s1 <= table_index;
			wt_s1 <= weight;
			last_s2 <= last_s1;
			idx_s2 <= idx_s1;
			wt_s2 <= wt_s1;
			last_q <= div_res.last;
			pixel_out_q <= div_res.pixel;
		end
	end

	assign cell_ctl = '{adv: adv, shift: pix_s1, rw_we: rw_s2, index: idx_s2, weight: wt_s2};

	for (genvar r = 0; r < SIDE; r++) begin : g_colin
		if (r < LROWS) begin : g_line
			assign colin[r] = line_rd_s1[r*PIX_W +: PIX_W];
		end else begin : g_new
			assign colin[r] = p_s1;
		end
	end

	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		logic [PIX_W-1:0] tin;
		if ((i % SIDE) == SIDE - 1) begin : g_edge
			assign tin = colin[i / SIDE];
		end else begin : g_inner
			assign tin = tap[i + 1];
		end
		bfw_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(cell_ctl),
			.sw_we(sw_s2 && (idx_s2 == bfw_pkg::INDEX_W'(i))),
			.tap_in(tin),
			.centre(tap[WINDOW_RADIUS * SIDE + WINDOW_RADIUS]),
			.tap(tap[i]),
			.prod(prods[i]),
			.wgt(wgts[i])
		);
	end

	bfw_adder_tree #(.N(TAPS), .W_IN(bfw_pkg::PROD_W), .W_OUT(NUM_W)) u_num_tree (
		.clk(clk),
		.adv(adv),
		.leaves(prods),
		.sum(num_sum)
	);

	bfw_adder_tree #(.N(TAPS), .W_IN(bfw_pkg::PRODW_W), .W_OUT(DEN_W)) u_den_tree (
		.clk(clk),
		.adv(adv),
		.leaves(wgts),
		.sum(den_sum)
	);

	bfw_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.num(num_sum),
		.den(den_sum),
		.meta_in(tree_meta_q[LEVELS-1]),
		.result(div_res)
	);

	assign result_valid = result_valid_q;
	assign pixel_out = pixel_out_q;
	assign last_of_frame = last_q;

	`BFW_ASSERT_ALWAYS(a_col_in_frame, PW_W'(column_count_q) < pw, "column count outside padded frame")
	`BFW_ASSERT_NEXT(a_frame_wrap, pix_acc && !write_en && is_last && (row_count_q == ph - ROW_W'(1)) && (PW_W'(col) == pw - PW_W'(1)), (column_count_q == '0) && (row_count_q == '0), "frame position did not wrap after last pixel")
	`BFW_ASSERT_NEXT(a_table_hold, accept && !write_en && (func != bfw_pkg::FUNC_PIXEL), $stable(column_count_q) && $stable(row_count_q), "table transfer moved frame position")
endmodule

FILE: tb/bilateral_filter_window_tb.sv
// Self-checking testbench of the streaming bilateral filter window.
`timescale 1ns / 1ps
module bilateral_filter_window_tb;
	import bfw_pkg::*;

	localparam int RAD = bfw_pkg::WINDOW_RADIUS;
	localparam int SIDE = 2 * RAD + 1;
	localparam int TAPS = SIDE * SIDE;
	localparam int LINE_LEN = bfw_pkg::MAX_WIDTH + 2 * RAD;
	localparam int SETTLE = 11 + 2 * RAD + 5 + 20;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic last;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] func = FUNC_PIXEL;
	logic [PIX_W-1:0] pixel = '0;
	logic [INDEX_W-1:0] table_index = '0;
	logic [WEIGHT_W-1:0] weight = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic last_of_frame;
	logic write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] write_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] write_data = '0;

	bilateral_filter_window DUT (.*);

	always #2 clk = ~clk;

	// Shadow copy of the filter state.
	logic [PIX_W-1:0] line_mem [0:2*RAD-1][0:LINE_LEN-1];
	logic [PIX_W-1:0] win [0:SIDE-1][0:SIDE-1];
	logic [WEIGHT_W-1:0] spatial_tab [0:TAPS-1];
	logic [WEIGHT_W-1:0] range_tab [0:255];
	int unsigned width_reg = 640;
	int unsigned height_reg = 480;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	filtered_t filtered_q[$];
	int errors = 0;
	int cycles = 0;
	int stall_left = 0;
	bit quiet = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PIX_W-1:0] weighted_mean();
		longint unsigned num, den, w;
		int unsigned ctr, q, diff;
		ctr = win[RAD][RAD];
		num = 0;
		den = 0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				q = win[r][c];
				diff = q >= ctr ? q - ctr : ctr - q;
				w = longint'(spatial_tab[r * SIDE + c]) * longint'(range_tab[diff]);
				den += w;
				num += w * q;
			end
		end
		if (den == 0)
			return ctr[PIX_W-1:0];
		return PIX_W'((2 * num + den) / (2 * den));
	endfunction

	function automatic void advance_filter(logic [1:0] f, logic [PIX_W-1:0] p,
			logic [INDEX_W-1:0] ti, logic [WEIGHT_W-1:0] wt);
		int unsigned w, h, pw, ph, col, row;
		logic [PIX_W-1:0] v;
		filtered_t res;
		if (f == FUNC_SPATIAL) begin
			if (ti < TAPS)
				spatial_tab[ti] = wt;
			return;
		end
		if (f == FUNC_RANGE) begin
			range_tab[ti] = wt;
			return;
		end
		if (f != FUNC_PIXEL)
			return;
		w = width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg;
		h = height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg;
		pw = w + 2 * RAD;
		ph = h + 2 * RAD;
		col = (col_pos >= pw || col_pos >= LINE_LEN) ? 0 : col_pos;
		row = row_pos;
		v = (row < RAD || row >= RAD + h || col < RAD || col >= RAD + w) ? '0 : p;
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c < SIDE - 1; c++)
				win[r][c] = win[r][c + 1];
		for (int k = 0; k < 2 * RAD; k++)
			win[k][SIDE-1] = line_mem[k][col];
		win[2*RAD][SIDE-1] = v;
		for (int k = 0; k + 1 < 2 * RAD; k++)
			line_mem[k][col] = line_mem[k+1][col];
		line_mem[2*RAD-1][col] = v;
		if (row >= 2 * RAD && row < ph && col >= 2 * RAD && col < pw) begin
			res.pixel = weighted_mean();
			res.last = (row == ph - 1 && col == pw - 1);
			filtered_q.push_back(res);
		end
		if (col + 1 >= pw) begin
			col_pos = 0;
			row_pos = (row + 1 >= ph) ? 0 : row + 1;
		end else begin
			col_pos = col + 1;
		end
	endfunction

	// Called just after a falling edge; returns just after a falling edge once the item has been accepted.
	task automatic send_item(logic [1:0] f, logic [PIX_W-1:0] p,
			logic [INDEX_W-1:0] ti, logic [WEIGHT_W-1:0] wt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		pixel = p;
		table_index = ti;
		weight = wt;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		advance_filter(f, p, ti, wt);
		@(negedge clk);
	endtask

	task automatic drain();
		int n;
		item_valid = 1'b0;
		n = 0;
		while (filtered_q.size() != 0 && n < 200000) begin
			@(negedge clk);
			n++;
		end
		if (filtered_q.size() != 0) begin
			$error("%0d filtered pixels never arrived", filtered_q.size());
			errors++;
			filtered_q.delete();
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_size(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
		drain();
		write_index = idx;
		write_data = CFG_DATA_W'(val);
		write_en = 1'b1;
		@(negedge clk);
		write_en = 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = val & 11'h7ff;
		else
			height_reg = val & 13'h1fff;
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		write_size(REG_IMAGE_WIDTH, w);
		write_size(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic stream_pixels(int unsigned n, int mode);
		logic [PIX_W-1:0] p;
		for (int unsigned i = 0; i < n; i++) begin
			case (mode)
				0: p = PIX_W'($urandom);
				1: p = (i % 3 == 0) ? 8'hff : 8'h00;
				default: p = 8'h80 + PIX_W'($urandom_range(0, 6)) - 8'd3;
			endcase
			send_item(FUNC_PIXEL, p, INDEX_W'($urandom), WEIGHT_W'($urandom));
		end
	endtask

	task automatic stream_frame(int unsigned w, int unsigned h, int mode);
		int unsigned pw, ph;
		pw = (w > MAX_WIDTH ? MAX_WIDTH : w) + 2 * RAD;
		ph = (h > MAX_HEIGHT ? MAX_HEIGHT : h) + 2 * RAD;
		stream_pixels(pw * ph, mode);
	endtask

	task automatic load_weights(int mode);
		logic [WEIGHT_W-1:0] wt;
		for (int i = 0; i < TAPS; i++) begin
			case (mode)
				0: wt = '0;
				1: wt = 16'hffff;
				default: wt = ($urandom_range(0, 9) == 0) ? '0 : WEIGHT_W'($urandom);
			endcase
			send_item(FUNC_SPATIAL, PIX_W'($urandom), INDEX_W'(i), wt);
		end
		if (mode == 0)
			return;
		for (int i = 0; i < 256; i++) begin
			case (mode)
				1: wt = 16'hffff;
				default: wt = ($urandom_range(0, 9) == 0) ? '0 : WEIGHT_W'($urandom);
			endcase
			send_item(FUNC_RANGE, PIX_W'($urandom), INDEX_W'(i), wt);
		end
	endtask

	task automatic test_directed();
		load_weights(1);
		send_item(FUNC_SPATIAL, 8'h00, 8'd25, 16'h0000);
		send_item(FUNC_SPATIAL, 8'hff, 8'hff, 16'h0000);
		send_item(FUNC_NONE, 8'hff, 8'hff, 16'hffff);
		set_frame(1, 1);
		stream_frame(1, 1, 1);
		set_frame(3, 2);
		stream_frame(3, 2, 1);
		stream_frame(3, 2, 2);
		// An all-zero spatial table leaves every centre pixel unchanged.
		load_weights(0);
		stream_frame(3, 2, 0);
		load_weights(2);
		stream_frame(3, 2, 0);
	endtask

	task automatic test_size_extremes();
		set_frame(0, 3);
		stream_frame(0, 3, 0);
		set_frame(2, 0);
		stream_frame(2, 0, 0);
		// Oversized sizes saturate; only the first 40 pixels of these frames are sent.
		set_frame(2047, 1);
		stream_pixels(40, 0);
		set_frame(1, 8191);
		stream_pixels(40, 2);
	endtask

	task automatic test_random_frames();
		int sent;
		int unsigned w, h, pw, ph, n;
		int r;
		sent = 0;
		while (sent < 250) begin
			quiet = ($urandom_range(0, 4) == 0);
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 6);
			set_frame(w, h);
			pw = w + 2 * RAD;
			ph = h + 2 * RAD;
			n = pw * ph * $urandom_range(1, 2);
			if ($urandom_range(0, 5) == 0)
				n = $urandom_range(1, pw * ph);
			for (int unsigned i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_item(FUNC_SPATIAL, PIX_W'($urandom), INDEX_W'($urandom),
						WEIGHT_W'($urandom));
				else if (r < 6)
					send_item(FUNC_RANGE, PIX_W'($urandom), INDEX_W'($urandom),
						WEIGHT_W'($urandom));
				else if (r < 8)
					send_item(FUNC_NONE, PIX_W'($urandom), INDEX_W'($urandom),
						WEIGHT_W'($urandom));
				else if (r < 50) begin
					send_item(FUNC_PIXEL, PIX_W'($urandom), INDEX_W'($urandom),
						WEIGHT_W'($urandom));
					sent++;
				end else begin
					send_item(FUNC_PIXEL, 8'h60 + PIX_W'($urandom_range(0, 15)),
						INDEX_W'($urandom), WEIGHT_W'($urandom));
					sent++;
				end
			end
		end
		quiet = 1'b0;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[bilateral_filter_window] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 20) begin
			stall_left <= pick_gap();
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		filtered_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (filtered_q.size() == 0) begin
				$error("unexpected transfer: pixel_out %0d", pixel_out);
				errors++;
			end else begin
				exp_res = filtered_q.pop_front();
				if (pixel_out !== exp_res.pixel) begin
					$error("pixel_out: expected %0d, actual %0d", exp_res.pixel, pixel_out);
					errors++;
				end
				if (last_of_frame !== exp_res.last) begin
					$error("last_of_frame: expected %0d, actual %0d", exp_res.last,
						last_of_frame);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < 2 * RAD; k++)
			for (int c = 0; c < LINE_LEN; c++)
				line_mem[k][c] = '0;
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c < SIDE; c++)
				win[r][c] = '0;
		for (int i = 0; i < TAPS; i++)
			spatial_tab[i] = '0;
		for (int i = 0; i < 256; i++)
			range_tab[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_size_extremes();
		test_random_frames();
		drain();
		if (errors == 0)
			$display("[bilateral_filter_window] OK");
		else
			$display("[bilateral_filter_window] ERROR");
		$finish;
	end
endmodule
